// ===== sv/toc_pkg.sv =====
// Shared constants, types and glyph ROM of the text overlay character generator.
package toc_pkg;

   localparam int OVERLAY_COLUMNS = 128;
   localparam int OVERLAY_ROWS    = 64;

   localparam int COL_W     = $clog2(OVERLAY_COLUMNS);
   localparam int ROW_W     = $clog2(OVERLAY_ROWS);
   localparam int PEN_COL_W = COL_W + 1;
   localparam int PEN_ROW_W = ROW_W + 1;

   localparam int GLYPH_W   = 5;
   localparam int GLYPH_H   = 7;
   localparam int ROW_CNT_W = $clog2(GLYPH_H);

   localparam int PEN_HOME   = 3;
   localparam int PEN_STEP_X = 6;
   localparam int PEN_STEP_Y = 8;

   localparam logic [7:0] ALPHA_RESET = 8'd160;
   localparam logic [7:0] COLOR_FULL  = 8'd255;
   localparam logic [7:0] COLOR_NONE  = 8'd0;

   localparam logic [1:0] FUNC_BEGIN = 2'd0;
   localparam logic [1:0] FUNC_DRAW  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [7:0] CHAR_END     = 8'd0;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DRAW_RD,
      ST_DRAW_WR,
      ST_PIX_OUT
   } ctl_state_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_BEGIN,
      KIND_END,
      KIND_NEWLINE,
      KIND_GLYPH,
      KIND_READ
   } item_kind_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic set_end;
      logic newline;
      logic mem_rd;
      logic pix_sel;
      logic mem_wr;
      logic row_next;
      logic pen_step;
      logic respond;
   } dp_cmd_type;

   typedef struct packed {
      item_kind_type kind;
      logic          last_row;
   } dp_status_type;

   // One glyph row, bit 4 is the leftmost pixel; unknown codes are blank.
   function automatic logic [GLYPH_W-1:0] glyph_row(input logic [7:0] code,
                                                    input logic [ROW_CNT_W-1:0] row);
      logic [GLYPH_W*GLYPH_H-1:0] g;
      int                         idx;
      logic [GLYPH_W-1:0]         result;
      case (code)
         8'h30: g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
         8'h31: g = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
         8'h32: g = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
         8'h33: g = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
         8'h34: g = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
         8'h35: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
         8'h36: g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
         8'h37: g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
         8'h38: g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
         8'h39: g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
         8'h41: g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
         8'h43: g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
         8'h45: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
         8'h48: g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
         8'h49: g = {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
         8'h4D: g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
         8'h4E: g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
         8'h4F: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
         8'h50: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
         8'h52: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
         8'h53: g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
         8'h54: g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
         8'h56: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
         8'h2F: g = {5'd1,  5'd2,  5'd2,  5'd4,  5'd8,  5'd8,  5'd16};
         8'h2E: g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
         8'h3A: g = {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0};
         8'h2D: g = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
         default: g = '0;
      endcase
      if (int'(row) < GLYPH_H) begin
         idx    = (GLYPH_H - 1 - int'(row)) * GLYPH_W;
         result = g[idx +: GLYPH_W];
      end else begin
         result = '0;
      end
      return result;
   endfunction

endpackage

// ===== sv/toc_ctrl.sv =====
// Controller state machine: sequences begin, draw and read items.
module toc_ctrl import toc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (status.kind)
               KIND_GLYPH: state_in = ST_DRAW_RD;
               KIND_READ:  state_in = ST_PIX_OUT;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_DRAW_RD: state_in = ST_DRAW_WR;
         ST_DRAW_WR: begin
            state_in = status.last_row ? ST_IDLE : ST_DRAW_RD;
         end
         ST_PIX_OUT: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: cmd.load = start;
         ST_DISPATCH: begin
            unique case (status.kind)
               KIND_BEGIN:   cmd.clear   = 1'b1;
               KIND_END:     cmd.set_end = 1'b1;
               KIND_NEWLINE: cmd.newline = 1'b1;
               KIND_READ: begin
                  cmd.mem_rd  = 1'b1;
                  cmd.pix_sel = 1'b1;
               end
               default: ;
            endcase
         end
         ST_DRAW_RD: cmd.mem_rd = 1'b1;
         ST_DRAW_WR: begin
            cmd.mem_wr   = 1'b1;
            cmd.row_next = 1'b1;
            cmd.pen_step = status.last_row;
         end
         ST_PIX_OUT: cmd.respond = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== sv/toc_dpath.sv =====
// Datapath: item registers, pen, overlay row store, glyph merge and pixel output.
module toc_dpath import toc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    req_func,
   input  logic [7:0]    req_char_code,
   input  logic [6:0]    req_pixel_x,
   input  logic [5:0]    req_pixel_y,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [7:0]    csr_background_alpha,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   output logic [7:0]    rsp_red,
   output logic [7:0]    rsp_green,
   output logic [7:0]    rsp_blue,
   output logic [7:0]    rsp_alpha
);

   logic [OVERLAY_COLUMNS-1:0] overlay_mem [OVERLAY_ROWS];

   logic [1:0]                 func_ff;
   logic [7:0]                 code_ff;
   logic [6:0]                 px_ff;
   logic [5:0]                 py_ff;
   logic [PEN_COL_W-1:0]       pen_col_ff, pen_col_in;
   logic [PEN_ROW_W-1:0]       pen_row_ff, pen_row_in;
   logic                       ended_ff, ended_in;
   logic [ROW_CNT_W-1:0]       row_cnt_ff, row_cnt_in;
   logic [7:0]                 alpha_ff, alpha_in;
   logic [OVERLAY_ROWS-1:0]    row_valid_ff;
   logic [OVERLAY_COLUMNS-1:0] rd_data_ff;
   logic                       rd_valid_ff;
   logic                       rsp_valid_ff;
   logic [7:0]                 rsp_color_ff, rsp_alpha_ff;

   logic                       row_full, col_full, pix_ok, pixel;
   logic [ROW_W-1:0]           draw_addr, mem_addr;
   logic [GLYPH_W-1:0]         glyph_bits, glyph_rev;
   logic [OVERLAY_COLUMNS-1:0] glyph_line, old_line, wr_data;

   assign csr_ready = 1'b1;

   // Item decode
   assign row_full = (PEN_ROW_W+1)'(pen_row_ff) + (PEN_ROW_W+1)'(GLYPH_H)
                     >= (PEN_ROW_W+1)'(OVERLAY_ROWS);
   assign col_full = (PEN_COL_W+1)'(pen_col_ff) + (PEN_COL_W+1)'(GLYPH_W)
                     >= (PEN_COL_W+1)'(OVERLAY_COLUMNS);

   always_comb begin
      status.last_row = (int'(row_cnt_ff) == GLYPH_H - 1);
      status.kind     = KIND_NONE;
      unique case (func_ff)
         FUNC_BEGIN: status.kind = KIND_BEGIN;
         FUNC_READ:  status.kind = KIND_READ;
         FUNC_DRAW: begin
            if (ended_ff || row_full) begin
               status.kind = KIND_NONE;
            end else if (code_ff == CHAR_END) begin
               status.kind = KIND_END;
            end else if (code_ff == CHAR_NEWLINE) begin
               status.kind = KIND_NEWLINE;
            end else if (col_full) begin
               status.kind = KIND_NONE;
            end else begin
               status.kind = KIND_GLYPH;
            end
         end
         default: status.kind = KIND_NONE;
      endcase
   end

   // Glyph row merge
   assign draw_addr  = ROW_W'(pen_row_ff + PEN_ROW_W'(row_cnt_ff));
   assign mem_addr   = cmd.pix_sel ? ROW_W'(py_ff) : draw_addr;
   assign glyph_bits = glyph_row(code_ff, row_cnt_ff);

   always_comb begin
      for (int i = 0; i < GLYPH_W; i++) begin
         glyph_rev[i] = glyph_bits[GLYPH_W-1-i];
      end
   end

   assign glyph_line = OVERLAY_COLUMNS'(glyph_rev) << pen_col_ff[COL_W-1:0];
   assign old_line   = rd_valid_ff ? rd_data_ff : '0;
   assign wr_data    = old_line | glyph_line;

   // Pixel lookup
   assign pix_ok = (32'(px_ff) < 32'(OVERLAY_COLUMNS)) && (32'(py_ff) < 32'(OVERLAY_ROWS));
   assign pixel  = pix_ok && rd_valid_ff && rd_data_ff[COL_W'(px_ff)];

   // Pen and control state
   always_comb begin
      pen_col_in = pen_col_ff;
      pen_row_in = pen_row_ff;
      ended_in   = ended_ff;
      row_cnt_in = row_cnt_ff;
      alpha_in   = alpha_ff;
      if (cmd.clear) begin
         pen_col_in = PEN_COL_W'(PEN_HOME);
         pen_row_in = PEN_ROW_W'(PEN_HOME);
         ended_in   = 1'b0;
      end
      if (cmd.set_end) ended_in = 1'b1;
      if (cmd.newline) begin
         pen_col_in = PEN_COL_W'(PEN_HOME);
         pen_row_in = pen_row_ff + PEN_ROW_W'(PEN_STEP_Y);
      end
      if (cmd.pen_step) pen_col_in = pen_col_ff + PEN_COL_W'(PEN_STEP_X);
      if (cmd.load) begin
         row_cnt_in = '0;
      end else if (cmd.row_next) begin
         row_cnt_in = row_cnt_ff + ROW_CNT_W'(1);
      end
      if (csr_valid && csr_ready) alpha_in = csr_background_alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_col_ff   <= PEN_COL_W'(PEN_HOME);
         pen_row_ff   <= PEN_ROW_W'(PEN_HOME);
         ended_ff     <= 1'b0;
         row_cnt_ff   <= '0;
         alpha_ff     <= ALPHA_RESET;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pen_col_ff   <= pen_col_in;
         pen_row_ff   <= pen_row_in;
         ended_ff     <= ended_in;
         row_cnt_ff   <= row_cnt_in;
         alpha_ff     <= alpha_in;
         rsp_valid_ff <= cmd.respond;
         if (cmd.clear) begin
            row_valid_ff <= '0;
         end else if (cmd.mem_wr) begin
            row_valid_ff[mem_addr] <= 1'b1;
         end
      end
   end

   // Item, read data and response payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         code_ff <= req_char_code;
         px_ff   <= req_pixel_x;
         py_ff   <= req_pixel_y;
      end
      if (cmd.mem_rd) begin
         rd_data_ff  <= overlay_mem[mem_addr];
         rd_valid_ff <= row_valid_ff[mem_addr];
      end
      if (cmd.respond) begin
         rsp_color_ff <= pixel ? COLOR_FULL : COLOR_NONE;
         rsp_alpha_ff <= pixel ? COLOR_FULL : alpha_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         overlay_mem[mem_addr] <= wr_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_color_ff;
   assign rsp_green = rsp_color_ff;
   assign rsp_blue  = rsp_color_ff;
   assign rsp_alpha = rsp_alpha_ff;

endmodule

// ===== sv/text_overlay_char_generator_unit.sv =====
// Top level of the text overlay character generator with 5x7 font.
//
//   channel   handshake                 payload
//   request   start / busy              req_func, req_char_code, req_pixel_x, req_pixel_y
//   response  rsp_valid (one cycle)     rsp_red, rsp_green, rsp_blue, rsp_alpha
//   csr       csr_valid / csr_ready     csr_background_alpha
//
// Begin, end, newline and skipped items pass through dispatch only; a read passes through dispatch and
// pixel output, and its beat leaves in the cycle that busy drops. A glyph draw makes seven
// read-modify-write passes over the single-port row store, each a read state and a write state.
// Reset clears the row valid bits at once, so the store reads as background without
// a clearing pass; begin does the same. The receiver cannot stall.
module text_overlay_char_generator_unit import toc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic [7:0] req_char_code,
   input  logic [6:0] req_pixel_x,
   input  logic [5:0] req_pixel_y,
   output logic       rsp_valid,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic [7:0] rsp_alpha,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_background_alpha
);

   dp_cmd_type    cmd;
   dp_status_type status;

   toc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   toc_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .req_func             (req_func),
      .req_char_code        (req_char_code),
      .req_pixel_x          (req_pixel_x),
      .req_pixel_y          (req_pixel_y),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_background_alpha (csr_background_alpha),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_red              (rsp_red),
      .rsp_green            (rsp_green),
      .rsp_blue             (rsp_blue),
      .rsp_alpha            (rsp_alpha)
   );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the text overlay character generator unit.
module testbench;
   import toc_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef logic [0:GLYPH_H-1][GLYPH_W-1:0] glyph_bits_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_func;
   logic [7:0] req_char_code;
   logic [6:0] req_pixel_x;
   logic [5:0] req_pixel_y;
   logic       rsp_valid;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic [7:0] rsp_alpha;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_background_alpha;

   logic [OVERLAY_COLUMNS-1:0] overlay_rows [OVERLAY_ROWS];
   int                         pen_x;
   int                         pen_y;
   bit                         text_closed;
   logic [7:0]                 bg_alpha;

   rgba_type expected_pixels [$];
   rgba_type want_pixel;
   int    error_count  = 0;
   bit    idle_allowed = 1'b1;
   bit    idle_now     = 1'b1;
   string font_chars   = "0123456789ACEHIMNOPRSTV/.:-";

   text_overlay_char_generator_unit uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_func             (req_func),
      .req_char_code        (req_char_code),
      .req_pixel_x          (req_pixel_x),
      .req_pixel_y          (req_pixel_y),
      .rsp_valid            (rsp_valid),
      .rsp_red              (rsp_red),
      .rsp_green            (rsp_green),
      .rsp_blue             (rsp_blue),
      .rsp_alpha            (rsp_alpha),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_background_alpha (csr_background_alpha)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // 5x7 font, top row first, bit 4 leftmost
   function automatic glyph_bits_type font_glyph(input logic [7:0] code);
      glyph_bits_type g;
      case (code)
         "0": g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
         "1": g = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
         "2": g = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
         "3": g = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
         "4": g = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
         "5": g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
         "6": g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
         "7": g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
         "8": g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
         "9": g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
         "A": g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
         "C": g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
         "E": g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
         "H": g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
         "I": g = {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
         "M": g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
         "N": g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
         "O": g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
         "P": g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
         "R": g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
         "S": g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
         "T": g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
         "V": g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
         "/": g = {5'd1,  5'd2,  5'd2,  5'd4,  5'd8,  5'd8,  5'd16};
         ".": g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
         ":": g = {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0};
         "-": g = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
         default: g = '0;
      endcase
      return g;
   endfunction

   function automatic void clear_overlay();
      for (int y = 0; y < OVERLAY_ROWS; y++) begin
         overlay_rows[y] = '0;
      end
      pen_x       = PEN_HOME;
      pen_y       = PEN_HOME;
      text_closed = 1'b0;
   endfunction

   function automatic void predict_overlay(input logic [1:0] func, input logic [7:0] code,
                                           input logic [6:0] px, input logic [5:0] py);
      glyph_bits_type g;
      rgba_type       pix;
      case (func)
         FUNC_BEGIN: clear_overlay();
         FUNC_DRAW: begin
            if (!text_closed && pen_y + GLYPH_H < OVERLAY_ROWS) begin
               if (code == CHAR_END) begin
                  text_closed = 1'b1;
               end else if (code == CHAR_NEWLINE) begin
                  pen_x = PEN_HOME;
                  pen_y += PEN_STEP_Y;
               end else if (pen_x + GLYPH_W < OVERLAY_COLUMNS) begin
                  g = font_glyph(code);
                  for (int r = 0; r < GLYPH_H; r++) begin
                     for (int c = 0; c < GLYPH_W; c++) begin
                        if (g[r][GLYPH_W-1-c]) overlay_rows[pen_y + r][pen_x + c] = 1'b1;
                     end
                  end
                  pen_x += PEN_STEP_X;
               end
            end
         end
         FUNC_READ: begin
            if (overlay_rows[py][px]) pix = {4{COLOR_FULL}};
            else pix = {COLOR_NONE, COLOR_NONE, COLOR_NONE, bg_alpha};
            expected_pixels.push_back(pix);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_channel(input string channel, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, channel, want, got);
         error_count++;
      end
   endfunction

   // pixel beats, checked against the oldest prediction
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t ns: unexpected pixel beat, expected none, actual %0d/%0d/%0d/%0d",
                     $time, rsp_red, rsp_green, rsp_blue, rsp_alpha);
            error_count++;
         end else begin
            want_pixel = expected_pixels.pop_front();
            check_channel("red",   want_pixel.red,   rsp_red);
            check_channel("green", want_pixel.green, rsp_green);
            check_channel("blue",  want_pixel.blue,  rsp_blue);
            check_channel("alpha", want_pixel.alpha, rsp_alpha);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t ns: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   // start is left high after a beat; whoever pauses the request side lowers it
   task automatic send_item(input logic [1:0] func, input logic [7:0] code,
                            input logic [6:0] px, input logic [5:0] py);
      if (idle_now && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      start         <= 1'b1;
      req_func      <= func;
      req_char_code <= code;
      req_pixel_x   <= px;
      req_pixel_y   <= py;
      do @(posedge clock); while (busy !== 1'b0);
      predict_overlay(func, code, px, py);
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_alpha(input logic [7:0] value);
      wait_quiet();
      if (idle_allowed) repeat ($urandom_range(0, 14)) @(posedge clock);
      csr_valid            <= 1'b1;
      csr_background_alpha <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      bg_alpha = value;
   endtask

   task automatic test_reset_readback();
      send_item(FUNC_READ, 8'h00, 7'd0, 6'd0);
      send_item(FUNC_READ, 8'hFF, 7'd127, 6'd63);
      send_item(FUNC_UNUSED, 8'hFF, 7'd127, 6'd63);
      send_item(FUNC_READ, 8'h5A, 7'd64, 6'd32);
   endtask

   task automatic test_glyph_draw();
      send_item(FUNC_BEGIN, 8'h00, 7'd0, 6'd0);
      send_item(FUNC_DRAW, "0", 7'd0, 6'd0);
      send_item(FUNC_READ, 8'h00, 7'd4, 6'd3);
      send_item(FUNC_READ, 8'h00, 7'd3, 6'd3);
      send_item(FUNC_READ, 8'h00, 7'd3, 6'd6);
      send_item(FUNC_DRAW, 8'hFF, 7'd127, 6'd63);   // no glyph, pen still moves
      send_item(FUNC_DRAW, "8", 7'd0, 6'd0);
      send_item(FUNC_READ, 8'h00, 7'd16, 6'd3);
      send_item(FUNC_DRAW, CHAR_NEWLINE, 7'd0, 6'd0);
      send_item(FUNC_DRAW, "-", 7'd0, 6'd0);
      send_item(FUNC_READ, 8'h00, 7'd7, 6'd14);
   endtask

   task automatic test_text_end();
      send_item(FUNC_DRAW, CHAR_END, 7'd0, 6'd0);
      send_item(FUNC_DRAW, "M", 7'd0, 6'd0);        // ignored after end
      send_item(FUNC_READ, 8'h00, 7'd9, 6'd11);
      send_item(FUNC_BEGIN, 8'hFF, 7'd127, 6'd63);
      send_item(FUNC_READ, 8'h00, 7'd4, 6'd3);
   endtask

   task automatic test_background_alpha();
      write_alpha(8'd0);
      send_item(FUNC_READ, 8'h00, 7'd0, 6'd0);
      write_alpha(8'd255);
      send_item(FUNC_READ, 8'h00, 7'd127, 6'd0);
   endtask

   // paragraphs of text lines running past the right and bottom edges, with probes
   task automatic test_random_text(input int item_total, input logic [7:0] alpha);
      int         sent;
      int         pick;
      logic [7:0] code;
      logic [6:0] px;
      logic [5:0] py;
      sent = 0;
      write_alpha(alpha);
      while (sent < item_total) begin
         idle_now = idle_allowed && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) != 0) begin
            send_item(FUNC_BEGIN, 8'($urandom()), 7'($urandom()), 6'($urandom()));
            sent++;
         end
         repeat ($urandom_range(1, 10)) begin
            if (sent >= item_total) break;
            repeat ($urandom_range(1, 24)) begin
               if (sent >= item_total) break;
               pick = $urandom_range(0, 99);
               if (pick < 2) begin
                  send_item(FUNC_UNUSED, 8'($urandom()), 7'($urandom()), 6'($urandom()));
               end else begin
                  if (pick < 72) code = font_chars[$urandom_range(0, font_chars.len() - 1)];
                  else if (pick < 98) code = 8'($urandom_range(0, 255));
                  else code = CHAR_END;
                  send_item(FUNC_DRAW, code, 7'($urandom()), 6'($urandom()));
               end
               sent++;
               if ($urandom_range(0, 2) == 0) begin
                  if ($urandom_range(0, 1) == 0) begin
                     px = 7'($urandom_range(0, 127));
                     py = 6'($urandom_range(0, 63));
                  end else begin
                     px = 7'((pen_x + 122 + $urandom_range(0, 5)) % OVERLAY_COLUMNS);
                     py = 6'((pen_y + $urandom_range(0, 6)) % OVERLAY_ROWS);
                  end
                  send_item(FUNC_READ, 8'($urandom()), px, py);
                  sent++;
               end
            end
            send_item(FUNC_DRAW, CHAR_NEWLINE, 7'($urandom()), 6'($urandom()));
            sent++;
         end
      end
   endtask

   initial begin
      reset                <= 1'b1;
      start                <= 1'b0;
      req_func             <= FUNC_BEGIN;
      req_char_code        <= 8'h00;
      req_pixel_x          <= 7'd0;
      req_pixel_y          <= 6'd0;
      csr_valid            <= 1'b0;
      csr_background_alpha <= 8'h00;
      clear_overlay();
      bg_alpha = ALPHA_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_readback();
      test_glyph_draw();
      test_text_end();
      test_background_alpha();
      test_random_text(350, 8'($urandom_range(1, 254)));
      test_random_text(350, 8'd0);
      test_random_text(350, 8'd255);
      idle_allowed = 1'b0;
      idle_now     = 1'b0;
      test_random_text(350, 8'($urandom_range(0, 255)));

      wait_quiet();
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
